[rtl/fsc_pkg.sv]
// Shared types and constants for the frustum sphere cull block.
// No dependencies; imported by the plane length unit and the top level.
package fsc_pkg;

  localparam int NumPlanes = 6;
  localparam int NumRegs   = 8;
  localparam int CoefW     = 33;  // sum of two Q16.16 entries, exact
  localparam int LenW      = 33;  // floor sqrt of a value below 2^66
  localparam int RadW      = 66;  // a^2 + b^2 + c^2

  localparam logic [2:0] NoPlane = 3'd6;

  typedef logic signed [CoefW-1:0] coef_t;

  typedef struct packed {
    coef_t a;
    coef_t b;
    coef_t c;
    coef_t d;
  } plane_t;

  typedef logic [LenW-1:0] len_t;

endpackage

[rtl/fsc_plane_len.sv]
// Plane normal length unit: squares each normal component on one shared
// multiplier, then takes a digit-by-digit floor square root. Uses fsc_pkg.
module fsc_plane_len import fsc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  input  plane_t planes_i [NumPlanes],
  output logic   busy_o,
  output len_t   len_o [NumPlanes]
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StSq   = 2'd1;
  localparam logic [1:0] StRoot = 2'd2;
  localparam int         RootSteps = RadW / 2;

  logic [1:0]        state_q, state_d;
  logic [2:0]        plane_q, plane_d;
  logic [1:0]        term_q, term_d;
  logic [5:0]        step_q, step_d;
  logic [RadW-1:0]   acc_q, acc_d;
  logic [LenW+3:0]   rem_q, rem_d;
  logic [LenW-1:0]   root_q, root_d;
  len_t              len_q [NumPlanes];

  plane_t            cur;
  coef_t             coef;
  logic signed [2*CoefW-1:0] sq;
  logic [LenW+3:0]   rem_sh, trial;

  always_comb begin
    cur = planes_i[plane_q];
    case (term_q)
      2'd0:    coef = cur.a;
      2'd1:    coef = cur.b;
      default: coef = cur.c;
    endcase
    sq = coef * coef;
    rem_sh = {rem_q[LenW+1:0], acc_q[RadW-1 -: 2]};
    trial  = {2'b00, root_q, 2'b01};
  end

  always_comb begin
    state_d = state_q;
    plane_d = plane_q;
    term_d  = term_q;
    step_d  = step_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    root_d  = root_q;
    case (state_q)
      StSq: begin
        acc_d = (term_q == 2'd0) ? sq[RadW-1:0] : acc_q + sq[RadW-1:0];
        if (term_q == 2'd2) begin
          state_d = StRoot;
          step_d  = '0;
          rem_d   = '0;
          root_d  = '0;
        end else begin
          term_d = term_q + 2'd1;
        end
      end
      StRoot: begin
        acc_d = acc_q << 2;
        if (rem_sh >= trial) begin
          rem_d  = rem_sh - trial;
          root_d = {root_q[LenW-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh;
          root_d = {root_q[LenW-2:0], 1'b0};
        end
        step_d = step_q + 6'd1;
        if (step_q == 6'(RootSteps - 1)) begin
          term_d = '0;
          if (plane_q == 3'(NumPlanes - 1)) begin
            state_d = StIdle;
          end else begin
            state_d = StSq;
            plane_d = plane_q + 3'd1;
          end
        end
      end
      default: ;
    endcase
    // restart the whole sweep on any register write
    if (start_i) begin
      state_d = StSq;
      plane_d = '0;
      term_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StSq;
      plane_q <= '0;
      term_q  <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      plane_q <= plane_d;
      term_q  <= term_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    if (state_q == StRoot && step_q == 6'(RootSteps - 1) && !start_i) begin
      len_q[plane_q] <= root_d;
    end
  end

  assign busy_o = (state_q != StIdle);
  assign len_o  = len_q;

endmodule

[rtl/frustum_sphere_cull.sv]
// Channel   Dir  Payload                               Handshake
// ------    ---  ------------------------------------  ---------------------
// cfg       in   cfg_idx_i, cfg_wdata_i                cfg_we_i
// sphere    in   center_x/y/z_i, radius_i              in_valid_i/in_ready_o
// result    out  outside_o, rejecting_plane_o,         out_valid_o/out_ready_i
//                degenerate_o
//
// One sphere per cycle while the output is not stalled and the plane length unit
// is idle; a sphere passes through product, partial sum, sign and encode stages.
// A downstream stall holds every stage in place. After reset and after each
// register write, the plane length unit sweeps six planes (3 squares plus 33
// root steps each), during which no sphere is taken.
module frustum_sphere_cull import fsc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [3:0]         cfg_idx_i,
  input  logic [63:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] center_x_i,
  input  logic signed [31:0] center_y_i,
  input  logic signed [31:0] center_z_i,
  input  logic [30:0]        radius_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               outside_o,
  output logic [2:0]         rejecting_plane_o,
  output logic               degenerate_o
);

  localparam int SumW = 70;

  logic [63:0] cfg_q [NumRegs];
  plane_t      planes [NumPlanes];
  len_t        lens [NumPlanes];
  logic        busy, start, advance;

  // matrix entry for column c of a register word: odd columns in the upper half
  function automatic logic signed [31:0] entry(input logic [63:0] w, input int c);
    entry = (c % 2 == 1) ? w[63:32] : w[31:0];
  endfunction

  always_comb begin
    for (int i = 0; i < NumPlanes; i++) begin
      coef_t e3 [4];
      coef_t ek [4];
      coef_t p  [4];
      for (int c = 0; c < 4; c++) begin
        e3[c] = CoefW'(entry(cfg_q[6 + c / 2], c));
        ek[c] = CoefW'(entry(cfg_q[(i / 2) * 2 + c / 2], c));
        p[c]  = (i % 2 == 1) ? e3[c] - ek[c] : e3[c] + ek[c];
      end
      planes[i] = '{a: p[0], b: p[1], c: p[2], d: p[3]};
    end
  end

  assign start = cfg_we_i && (cfg_idx_i < 4'(NumRegs));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[0] <= 64'h0000_0000_0001_0000;
      cfg_q[1] <= 64'h0;
      cfg_q[2] <= 64'h0001_0000_0000_0000;
      cfg_q[3] <= 64'h0;
      cfg_q[4] <= 64'h0;
      cfg_q[5] <= 64'h0000_0000_0001_0000;
      cfg_q[6] <= 64'h0;
      cfg_q[7] <= 64'h0001_0000_0000_0000;
    end else if (start) begin
      cfg_q[cfg_idx_i[2:0]] <= cfg_wdata_i;
    end
  end

  fsc_plane_len u_len (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .planes_i (planes),
    .busy_o   (busy),
    .len_o    (lens)
  );

  assign advance    = !out_valid_o || out_ready_i;
  assign in_ready_o = advance && !busy;

  // stage 1: products
  logic                  v1_q;
  logic signed [64:0]    pa_q [NumPlanes];
  logic signed [64:0]    pb_q [NumPlanes];
  logic signed [64:0]    pc_q [NumPlanes];
  logic signed [48:0]    pd_q [NumPlanes];
  logic signed [65:0]    pr_q [NumPlanes];
  // stage 2: partial sums
  logic                  v2_q;
  logic signed [SumW-1:0] s1_q [NumPlanes];
  logic signed [SumW-1:0] s2_q [NumPlanes];
  logic signed [SumW-1:0] s3_q [NumPlanes];
  // stage 3: per-plane reject flags
  logic                  v3_q;
  logic [NumPlanes-1:0]  rej_q;
  logic [NumPlanes-1:0]  rej_d;
  logic [NumPlanes-1:0]  zero;
  logic [2:0]            first_rej;

  always_comb begin
    for (int i = 0; i < NumPlanes; i++) begin
      zero[i]  = (lens[i] == '0);
      rej_d[i] = !zero[i] && (s1_q[i] + s2_q[i] + s3_q[i] < 0);
    end
  end

  // first rejecting plane wins
  always_comb begin
    first_rej = NoPlane;
    for (int i = NumPlanes - 1; i >= 0; i--) begin
      if (rej_q[i]) first_rej = 3'(i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (advance) begin
      v1_q        <= in_valid_i && in_ready_o;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_o <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int i = 0; i < NumPlanes; i++) begin
        pa_q[i] <= planes[i].a * center_x_i;
        pb_q[i] <= planes[i].b * center_y_i;
        pc_q[i] <= planes[i].c * center_z_i;
        pd_q[i] <= {planes[i].d, 16'h0};
        pr_q[i] <= $signed({1'b0, radius_i}) * $signed({1'b0, lens[i]});
        s1_q[i] <= SumW'(pa_q[i]) + SumW'(pb_q[i]);
        s2_q[i] <= SumW'(pc_q[i]) + SumW'(pd_q[i]);
        s3_q[i] <= SumW'(pr_q[i]);
      end
      rej_q             <= rej_d;
      rejecting_plane_o <= first_rej;
      outside_o         <= |rej_q;
      degenerate_o      <= |zero;
    end
  end

endmodule
